[rtl/assert_macros.svh]
// assertion macros used by the rtl top level
// needs a clock named clk and an active high reset named rst in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[rtl/rfpd_pkg.sv]
// types and constants for the rocket flight phase detector
// no dependencies
`timescale 1ns / 1ps
package rfpd_pkg;

  localparam int BURNOUT_WINDOW = 20;
  localparam int APOGEE_RUN     = 20;

  localparam int PTR_W = $clog2(BURNOUT_WINDOW);
  localparam int CNT_W = $clog2(BURNOUT_WINDOW + 1);
  localparam int SUM_W = 16 + CNT_W;
  localparam int RUN_W = 6;
  localparam logic [RUN_W-1:0] RUN_MAX = '1;

  localparam logic signed [24:0] LANDING_HEIGHT_CM = 25'sd5000;

  localparam int ROOT_STEPS = 16;

  // configuration register indexes
  localparam logic [2:0] REG_GROUND_ALT   = 3'd0;
  localparam logic [2:0] REG_LIFTOFF_ACC  = 3'd1;
  localparam logic [2:0] REG_LIFTOFF_HGT  = 3'd2;
  localparam logic [2:0] REG_BURNOUT_ACC  = 3'd3;
  localparam logic [2:0] REG_BURNOUT_TIME = 3'd4;
  localparam logic [2:0] REG_COAST_HGT    = 3'd5;
  localparam logic [2:0] REG_LANDING_ACC  = 3'd6;
  localparam logic [2:0] REG_LANDING_TIME = 3'd7;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ARMED   = 3'd1,
    PH_POWERED = 3'd2,
    PH_COAST   = 3'd3,
    PH_APOGEE  = 3'd4,
    PH_DESCENT = 3'd5,
    PH_LANDED  = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_MX   = 3'd1,
    S_MY   = 3'd2,
    S_MZ   = 3'd3,
    S_MB   = 3'd4,
    S_ROOT = 3'd5,
    S_DONE = 3'd6
  } seq_t;

endpackage

[rtl/rocket_flight_phase_detector_top.sv]
// rocket flight phase detector, top level
// uses rfpd_pkg and assert_macros.svh
`timescale 1ns / 1ps
// usage
// - s_axis carries one control tick per word: three signed accelerations,
//   barometric altitude and microsecond time
// - m_axis returns one word per tick: phase, phase changed flag, control
//   active flag and the acceleration magnitude
// - cfg_we/cfg_addr/cfg_data write the eight threshold registers; the user must
//   write them only while the block has no tick in flight, the block itself
//   does not enforce it
// - a new tick is taken only once the last one has left the sequencer;
//   s_axis_tready is high only while the sequencer sits idle
// - the three squares and the burnout product take four passes through the one
//   shared 16x16 multiplier, then the 16 step digit-by-digit square root follows
// - a finished word waits in the output register; the next tick can be taken
//   meanwhile, and its result waits in the last sequencer step while the
//   receiver stalls
// - reset (synchronous, active high) puts the phase in armed, empties the
//   magnitude window and the descent run, clears the stillness timer and
//   loads the default thresholds; the ring and the prior altitude are not
//   cleared, they are only read once written
`include "assert_macros.svh"

module rocket_flight_phase_detector_top import rfpd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  // accel_x[15:0], accel_y[31:16], accel_z[47:32], altitude[71:48], time_us[103:72]
  input  logic [103:0] s_axis_tdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // phase[2:0], phase_changed[3], control_active[4], accel_magnitude[20:5], zero pad
  output logic [23:0]  m_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_data
);

  // configuration registers
  logic signed [23:0] ground_altitude;
  logic [15:0] liftoff_accel;
  logic [22:0] liftoff_height;
  logic [15:0] burnout_accel;
  logic [31:0] burnout_min_time;
  logic [22:0] coast_exit_height;
  logic [15:0] landing_accel;
  logic [31:0] landing_hold_time;

  // sequencer
  seq_t state, state_next;

  // captured tick
  logic signed [15:0] ax, ay, az;
  logic signed [23:0] alt_in;
  logic [31:0] time_in;

  // shared multiplier and square root datapath
  logic [15:0] mul_a, mul_b;
  logic [31:0] prod;
  logic [31:0] acc;
  logic [17:0] rem;
  logic [15:0] root;
  logic [3:0]  iter;
  logic [17:0] rem_sh, trial;

  // flight state
  phase_t phase_reg;
  logic [31:0] liftoff_stamp;
  logic [15:0] magnitude_ring [BURNOUT_WINDOW];
  logic [PTR_W-1:0] ring_pointer;
  logic [SUM_W-1:0] window_sum;
  logic [CNT_W-1:0] sample_count;
  logic signed [23:0] prior_altitude;
  logic [RUN_W-1:0] descent_run;
  logic [31:0] still_since;
  logic still_valid;

  // output register
  logic [2:0]  out_phase;
  logic        out_changed, out_ctl;
  logic [15:0] out_mag;
  logic        out_valid;

  logic accept, finish, ring_full, had_prior;
  logic [CNT_W-1:0] count_new;
  logic [SUM_W-1:0] sum_new;
  logic [RUN_W-1:0] run_new;
  logic signed [24:0] height;
  phase_t phase_new;
  logic still_valid_new;
  logic [31:0] still_since_new, stamp_new;

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    abs16 = v[15] ? 16'(~v + 16'd1) : v;
  endfunction

  assign s_axis_tready = (state == S_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign finish = (state == S_DONE) && (!out_valid || m_axis_tready);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_mag, out_ctl, out_changed, out_phase};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ground_altitude   <= '0;
      liftoff_accel     <= 16'd2560;
      liftoff_height    <= 23'd1000;
      burnout_accel     <= 16'd640;
      burnout_min_time  <= 32'd3000000;
      coast_exit_height <= 23'd5000;
      landing_accel     <= 16'd256;
      landing_hold_time <= 32'd3000000;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GROUND_ALT:   ground_altitude   <= cfg_data[23:0];
        REG_LIFTOFF_ACC:  liftoff_accel     <= cfg_data[15:0];
        REG_LIFTOFF_HGT:  liftoff_height    <= cfg_data[22:0];
        REG_BURNOUT_ACC:  burnout_accel     <= cfg_data[15:0];
        REG_BURNOUT_TIME: burnout_min_time  <= cfg_data;
        REG_COAST_HGT:    coast_exit_height <= cfg_data[22:0];
        REG_LANDING_ACC:  landing_accel     <= cfg_data[15:0];
        REG_LANDING_TIME: landing_hold_time <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state and multiplier operand select
  always_comb begin
    state_next = state;
    mul_a = abs16(ax);
    mul_b = abs16(ax);
    case (state)
      S_IDLE: if (accept) state_next = S_MX;
      S_MX:   state_next = S_MY;
      S_MY: begin
        mul_a = abs16(ay);
        mul_b = abs16(ay);
        state_next = S_MZ;
      end
      S_MZ: begin
        mul_a = abs16(az);
        mul_b = abs16(az);
        state_next = S_MB;
      end
      S_MB: begin
        // burnout threshold times the count after this tick
        mul_a = burnout_accel;
        mul_b = 16'(count_new);
        state_next = S_ROOT;
      end
      S_ROOT: if (iter == 4'(ROOT_STEPS - 1)) state_next = S_DONE;
      S_DONE: if (finish) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // one square root digit per cycle
  assign rem_sh = {rem[15:0], acc[31:30]};
  assign trial  = {root, 2'b01};

  // datapath: capture, multiply-accumulate, square root
  always_ff @(posedge clk) begin
    if (accept) begin
      ax      <= s_axis_tdata[15:0];
      ay      <= s_axis_tdata[31:16];
      az      <= s_axis_tdata[47:32];
      alt_in  <= s_axis_tdata[71:48];
      time_in <= s_axis_tdata[103:72];
    end
    // the burnout product is held through the root steps for the final compare
    if ((state != S_ROOT) && (state != S_DONE)) prod <= 32'(mul_a) * 32'(mul_b);
    case (state)
      S_MY: acc <= prod;
      S_MZ: acc <= acc + prod;
      S_MB: begin
        acc  <= acc + prod;
        rem  <= '0;
        root <= '0;
        iter <= '0;
      end
      S_ROOT: begin
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[14:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[14:0], 1'b0};
        end
        acc  <= {acc[29:0], 2'b00};
        iter <= iter + 4'd1;
      end
      default: ;
    endcase
  end

  // per tick update, all from the finished magnitude in root
  assign ring_full = (sample_count == CNT_W'(BURNOUT_WINDOW));
  assign had_prior = (sample_count != '0);
  assign count_new = ring_full ? sample_count : sample_count + CNT_W'(1);
  // window_sum already had the leaving entry taken out in the first multiply step
  assign sum_new   = window_sum + SUM_W'(root);
  assign height    = 25'(alt_in) - 25'(ground_altitude);

  always_comb begin
    if (had_prior && (alt_in < prior_altitude))
      run_new = (descent_run == RUN_MAX) ? descent_run : descent_run + RUN_W'(1);
    else
      run_new = '0;
  end

  always_comb begin
    phase_new       = phase_reg;
    stamp_new       = liftoff_stamp;
    still_valid_new = still_valid;
    still_since_new = still_since;
    case (phase_reg)
      PH_ARMED: begin
        if ((root > liftoff_accel) || (height > $signed({2'b00, liftoff_height}))) begin
          phase_new = PH_POWERED;
          stamp_new = time_in;
        end
      end
      PH_POWERED: begin
        if ((32'(sum_new) < prod) && ((time_in - liftoff_stamp) > burnout_min_time))
          phase_new = PH_COAST;
      end
      PH_COAST: begin
        if (height > $signed({2'b00, coast_exit_height})) phase_new = PH_APOGEE;
      end
      PH_APOGEE: begin
        if (({1'b0, run_new} + 7'd1) >= 7'(APOGEE_RUN)) phase_new = PH_DESCENT;
      end
      PH_DESCENT: begin
        if ((height < LANDING_HEIGHT_CM) && (root < landing_accel)) begin
          if (!still_valid) begin
            still_valid_new = 1'b1;
            still_since_new = time_in;
          end else if ((time_in - still_since) > landing_hold_time) begin
            phase_new = PH_LANDED;
          end
        end else begin
          still_valid_new = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // flight state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= PH_ARMED;
      liftoff_stamp <= '0;
      ring_pointer  <= '0;
      window_sum    <= '0;
      sample_count  <= '0;
      descent_run   <= '0;
      still_since   <= '0;
      still_valid   <= 1'b0;
    end else if (state == S_MX) begin
      if (ring_full) window_sum <= window_sum - SUM_W'(magnitude_ring[ring_pointer]);
    end else if (finish) begin
      phase_reg     <= phase_new;
      liftoff_stamp <= stamp_new;
      window_sum    <= sum_new;
      sample_count  <= count_new;
      ring_pointer  <= (ring_pointer == PTR_W'(BURNOUT_WINDOW - 1)) ? '0
                                                                    : ring_pointer + PTR_W'(1);
      descent_run   <= run_new;
      still_since   <= still_since_new;
      still_valid   <= still_valid_new;
    end
  end

  // ring and prior altitude need no reset, they are read only once written
  always_ff @(posedge clk) begin
    if (finish) begin
      magnitude_ring[ring_pointer] <= root;
      prior_altitude               <= alt_in;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_phase   <= phase_new;
      out_changed <= (phase_new != phase_reg);
      out_ctl     <= (phase_new == PH_COAST) || (phase_new == PH_APOGEE);
      out_mag     <= root;
    end
  end

  `ASSERT_NEXT(a_accept_starts, accept, state == S_MX, "accepted word did not start the sequence")
  `ASSERT_ALWAYS(a_count_range, sample_count <= CNT_W'(BURNOUT_WINDOW), "sample count over window")
  `ASSERT_ALWAYS(a_ptr_range, ring_pointer < PTR_W'(BURNOUT_WINDOW), "ring pointer out of range")
  `ASSERT_ALWAYS(a_ctl_flag,
                 !out_valid || (out_ctl == ((out_phase == PH_COAST) || (out_phase == PH_APOGEE))),
                 "control flag disagrees with phase")
  `ASSERT_ALWAYS(a_never_idle, phase_reg != PH_IDLE, "phase fell back to idle")

endmodule

[test/tb_rocket_flight_phase_detector_top.sv]
// testbench for rocket_flight_phase_detector_top: flies whole flights through the phases
// and checks every output word against a predictor kept in a scoreboard class
// needs rfpd_pkg and the rtl top level, nothing else
`timescale 1ns / 1ps

module tb_rocket_flight_phase_detector_top;
  import rfpd_pkg::*;

  localparam int TICK_TARGET = 1350;
  // cycles with no handshake on either side before the run is declared hung
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_OFF    = 300;
  localparam int MAX_REPORTS = 40;

  logic         clk;
  logic         rst;
  logic [103:0] s_axis_tdata;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [23:0]  m_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic         cfg_we;
  logic [2:0]   cfg_addr;
  logic [31:0]  cfg_data;

  // one expected output word
  typedef struct packed {
    phase_t      phase;
    logic        changed;
    logic        active;
    logic [15:0] mag;
  } flight_word_t;

  // predictor of the phase machine plus the queue of words still owed by the block
  class phase_scoreboard;
    int          ground_cm;
    int unsigned liftoff_acc, liftoff_hgt, burnout_acc, burnout_us;
    int unsigned coast_hgt, landing_acc, landing_us;

    phase_t      phase;
    int unsigned liftoff_t;
    int unsigned mag_ring[BURNOUT_WINDOW];
    int          ring_idx;
    int unsigned mag_sum;
    int          fill;
    int          prev_alt;
    int          fall_run;
    int unsigned still_t;
    bit          still_on;

    flight_word_t expected_words[$];
    int           errors;
    int           words_seen;

    function new();
      ground_cm   = 0;
      liftoff_acc = 2560;
      liftoff_hgt = 1000;
      burnout_acc = 640;
      burnout_us  = 3000000;
      coast_hgt   = 5000;
      landing_acc = 256;
      landing_us  = 3000000;
      phase       = PH_ARMED;
      liftoff_t   = 0;
      ring_idx    = 0;
      mag_sum     = 0;
      fill        = 0;
      prev_alt    = 0;
      fall_run    = 0;
      still_t     = 0;
      still_on    = 0;
      errors      = 0;
      words_seen  = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      logic signed [23:0] g;
      g = val[23:0];
      case (idx)
        REG_GROUND_ALT:   ground_cm   = g;
        REG_LIFTOFF_ACC:  liftoff_acc = val[15:0];
        REG_LIFTOFF_HGT:  liftoff_hgt = val[22:0];
        REG_BURNOUT_ACC:  burnout_acc = val[15:0];
        REG_BURNOUT_TIME: burnout_us  = val;
        REG_COAST_HGT:    coast_hgt   = val[22:0];
        REG_LANDING_ACC:  landing_acc = val[15:0];
        REG_LANDING_TIME: landing_us  = val;
        default: ;
      endcase
    endfunction

    // floor square root, one result bit at a time from the top
    function int unsigned root_floor(longint unsigned v);
      int unsigned r;
      int unsigned trial;
      r = 0;
      for (int b = 15; b >= 0; b--) begin
        trial = r | (32'd1 << b);
        if (longint'(trial) * longint'(trial) <= v) r = trial;
      end
      return r;
    endfunction

    // accepted tick: step the model and queue the word it must produce
    function void note_tick(logic [103:0] w);
      logic signed [15:0] ax, ay, az;
      logic signed [23:0] alt24;
      int                 alt, height;
      longint unsigned    sq;
      int unsigned        mag, now;
      phase_t             was;
      bit                 had_prev;
      flight_word_t       e;
      ax    = w[15:0];
      ay    = w[31:16];
      az    = w[47:32];
      alt24 = w[71:48];
      now   = w[103:72];
      alt   = alt24;
      sq    = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
      mag   = root_floor(sq);
      height   = alt - ground_cm;
      had_prev = fill != 0;
      was      = phase;

      // magnitude window
      if (fill >= BURNOUT_WINDOW) mag_sum -= mag_ring[ring_idx];
      else fill++;
      mag_ring[ring_idx] = mag;
      mag_sum += mag;
      ring_idx = (ring_idx == BURNOUT_WINDOW - 1) ? 0 : ring_idx + 1;

      // run of strict altitude drops, nothing to compare on the first tick
      if (had_prev && alt < prev_alt) begin
        if (fall_run < RUN_MAX) fall_run++;
      end else begin
        fall_run = 0;
      end
      prev_alt = alt;

      case (phase)
        PH_ARMED: begin
          if (mag > liftoff_acc || height > int'(liftoff_hgt)) begin
            phase     = PH_POWERED;
            liftoff_t = now;
          end
        end
        PH_POWERED: begin
          if (mag_sum < burnout_acc * fill && (now - liftoff_t) > burnout_us) phase = PH_COAST;
        end
        PH_COAST: begin
          if (height > int'(coast_hgt)) phase = PH_APOGEE;
        end
        PH_APOGEE: begin
          if (fall_run >= APOGEE_RUN - 1) phase = PH_DESCENT;
        end
        PH_DESCENT: begin
          if (height < LANDING_HEIGHT_CM && mag < landing_acc) begin
            if (!still_on) begin
              still_on = 1;
              still_t  = now;
            end else if ((now - still_t) > landing_us) begin
              phase = PH_LANDED;
            end
          end else begin
            still_on = 0;
          end
        end
        default: ;
      endcase

      e.phase   = phase;
      e.changed = phase != was;
      e.active  = (phase == PH_COAST) || (phase == PH_APOGEE);
      e.mag     = mag[15:0];
      expected_words.push_back(e);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    task report(string what, int got, int want);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("mismatch at word %0d: %s is %0h, expected %0h", words_seen, what, got, want);
    endtask

    task check_word(logic [23:0] w);
      flight_word_t e;
      if (expected_words.size() == 0) begin
        report("word with nothing pending", w, 0);
        return;
      end
      e = expected_words.pop_front();
      words_seen++;
      if (w[2:0] !== e.phase)    report("phase", w[2:0], e.phase);
      if (w[3] !== e.changed)    report("phase_changed", w[3], e.changed);
      if (w[4] !== e.active)     report("control_active", w[4], e.active);
      if (w[20:5] !== e.mag)     report("accel_magnitude", w[20:5], e.mag);
    endtask
  endclass

  phase_scoreboard sb;

  int          ticks_sent;
  int          idle_cycles;
  bit          burst;      // both sides run with no gaps while set
  bit          hold_req;   // asks the receiver for one long hold-off
  int          alt_now;    // current flight altitude, cm
  int unsigned clock_us;   // current flight time, us

  rocket_flight_phase_detector_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int rnd(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // accel_x[15:0], accel_y[31:16], accel_z[47:32], altitude[71:48], time_us[103:72]
  function automatic logic [103:0] pack_tick(int ax, int ay, int az, int alt, int unsigned t);
    return {t, alt[23:0], az[15:0], ay[15:0], ax[15:0]};
  endfunction

  // offer one word after a random gap and hold it until the block takes it
  task automatic send_tick(logic [103:0] w);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= w;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_tick(w);
    ticks_sent++;
  endtask

  // every bit of every field random
  task automatic noise_tick();
    logic [127:0] r;
    r = {$urandom(), $urandom(), $urandom(), $urandom()};
    send_tick(r[103:0]);
  endtask

  // one flight tick: cross axes within +-span, z in its own range, altitude moves by climb
  task automatic fly_tick(int span, int z_lo, int z_hi, int climb_lo, int climb_hi);
    alt_now  += rnd(climb_lo, climb_hi);
    clock_us += rnd(1000, 15000);
    send_tick(pack_tick(rnd(-span, span), rnd(-span, span), rnd(z_lo, z_hi), alt_now, clock_us));
  endtask

  // stop offering and wait until the block has returned every word
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // output side: random stall per word, one long hold-off on request
  initial begin
    int n;
    forever begin
      if (hold_req) begin
        hold_req = 0;
        n = HOLD_OFF;
      end else begin
        n = burst ? 0 : $urandom_range(0, 9);
      end
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
  end

  // hang detector
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int gnd;
    int lift_hgt;
    int guard;
    sb         = new();
    ticks_sent = 0;
    burst      = 0;
    hold_req   = 0;
    alt_now    = 0;
    clock_us   = 0;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we        <= 1'b0;
    cfg_addr      <= REG_GROUND_ALT;
    cfg_data      <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset thresholds: first tick has no prior altitude, then liftoff limits hit exactly
    send_tick(pack_tick(0, 0, 0, 0, 0));
    send_tick(pack_tick(2560, 0, 0, 1000, 100));
    send_tick(pack_tick(-1, -1, -1, 999, 200));
    settle();

    // liftoff out of reach so the field extremes can be fed while armed
    write_reg(REG_LIFTOFF_ACC, 32'h0000_FFFF);
    write_reg(REG_LIFTOFF_HGT, 32'h007F_FFFF);
    send_tick(pack_tick(-32768, -32768, -32768, 8388607, 32'hFFFF_FFFF));
    send_tick(pack_tick(32767, 32767, 32767, -8388608, 32'h0000_0000));
    send_tick(pack_tick(-32768, 0, 0, 24'h555555, 32'h5555_5555));
    send_tick(pack_tick(0, 32767, 0, 24'hAAAAAA, 32'hAAAA_AAAA));
    send_tick(pack_tick(0, 0, -32768, 0, 1));
    send_tick(pack_tick(3, 4, 0, 100, 2));
    send_tick(pack_tick(1, 2, 2, 99, 3));
    send_tick(pack_tick(-6, 0, 8, 98, 4));
    send_tick(pack_tick(2, 3, 6, 98, 5));
    send_tick(pack_tick(1, 1, 1, 97, 6));
    send_tick(pack_tick(255, 255, 255, 96, 7));
    send_tick(pack_tick(1, 1, 0, 200, 8));
    settle();

    // armed with the pad at the top of the range: height never positive
    write_reg(REG_GROUND_ALT, 32'h007F_FFFF);
    write_reg(REG_LIFTOFF_HGT, $urandom());
    write_reg(REG_BURNOUT_ACC, $urandom());
    write_reg(REG_BURNOUT_TIME, $urandom());
    write_reg(REG_COAST_HGT, $urandom());
    write_reg(REG_LANDING_ACC, $urandom());
    write_reg(REG_LANDING_TIME, $urandom());
    repeat (50) noise_tick();
    burst = 1;
    repeat (50) noise_tick();
    burst = 0;
    settle();

    // flight setup: burnout, apogee and landing held off for now
    gnd      = rnd(0, 1000000);
    lift_hgt = rnd(500, 2000);
    write_reg(REG_GROUND_ALT, gnd);
    write_reg(REG_LIFTOFF_ACC, rnd(1000, 4000));
    write_reg(REG_LIFTOFF_HGT, lift_hgt);
    write_reg(REG_BURNOUT_ACC, 32'h0);
    write_reg(REG_BURNOUT_TIME, rnd(100000, 2000000));
    write_reg(REG_COAST_HGT, 32'h007F_FFFF);
    write_reg(REG_LANDING_ACC, 32'h0);
    write_reg(REG_LANDING_TIME, 32'hFFFF_FFFF);
    // start near the top of the clock so time wraps mid flight
    clock_us = 32'hFFFF_FFFF - $urandom_range(0, 3000000);

    // sitting on the pad
    repeat (rnd(10, 30)) begin
      alt_now = gnd + rnd(-200, 200);
      fly_tick(300, -300, 300, 0, 0);
    end
    // liftoff either by thrust or by barometric height
    guard = 0;
    while (sb.phase == PH_ARMED && guard < 10) begin
      guard++;
      if ($urandom_range(0, 1)) begin
        alt_now = gnd + rnd(-200, 200);
        fly_tick(2000, 20000, 30000, 0, 0);
      end else begin
        alt_now = gnd + lift_hgt + rnd(1, 500);
        fly_tick(300, -300, 300, 0, 0);
      end
    end

    // powered climb; the receiver holds off once so the block backs up
    hold_req = 1;
    repeat (200) fly_tick(2000, 3000, 30000, 500, 3000);
    settle();

    // average always below the limit but the burn time can never run out
    write_reg(REG_BURNOUT_ACC, 32'h0000_FFFF);
    write_reg(REG_BURNOUT_TIME, 32'hFFFF_FFFF);
    burst = 1;
    repeat (60) fly_tick(2000, 3000, 30000, 500, 3000);
    burst = 0;
    settle();

    // thrust dies away; burnout once the window average drops below the limit
    write_reg(REG_BURNOUT_ACC, rnd(400, 1000));
    write_reg(REG_BURNOUT_TIME, 32'h0);
    guard = 0;
    while (sb.phase == PH_POWERED && guard < 60) begin
      guard++;
      fly_tick(150, -150, 150, 50, 1500);
    end

    // coasting with the exit height out of reach
    burst = $urandom_range(0, 1);
    repeat (150) fly_tick(150, -150, 150, 50, 1500);
    burst = 0;
    settle();

    // exit height a little above the current height
    write_reg(REG_COAST_HGT, (alt_now - gnd) + rnd(1000, 30000));
    guard = 0;
    while (sb.phase == PH_COAST && guard < 200) begin
      guard++;
      fly_tick(150, -150, 150, 100, 2000);
    end

    // around the top: altitude wanders and keeps breaking the drop run
    repeat (150) begin
      if ($urandom_range(0, 3) == 0) fly_tick(200, -200, 200, 0, 0);
      else fly_tick(200, -200, 200, -300, 300);
    end
    // steady fall until the run is long enough
    guard = 0;
    while (sb.phase == PH_APOGEE && guard < 40) begin
      guard++;
      fly_tick(200, -200, 200, -500, -1);
    end

    // descent to no more than 80 m above the ground, landing still disabled
    guard = 0;
    while (alt_now - gnd > 8000 && guard < 400) begin
      guard++;
      fly_tick(400, -400, 400, -8000, -1000);
    end
    settle();

    // always still but the hold never ends; height crosses the landing limit
    write_reg(REG_LANDING_ACC, 32'h0000_FFFF);
    write_reg(REG_LANDING_TIME, 32'hFFFF_FFFF);
    repeat (40) begin
      alt_now = ($urandom_range(0, 7) == 0) ? gnd + 5000 : gnd + rnd(2000, 8000);
      fly_tick(3000, -3000, 3000, 0, 0);
    end
    settle();

    // real landing: still below 50 m for the hold, with occasional bumps
    write_reg(REG_LANDING_ACC, rnd(300, 2000));
    write_reg(REG_LANDING_TIME, rnd(20000, 300000));
    guard = 0;
    while (sb.phase != PH_LANDED && guard < 400) begin
      guard++;
      alt_now = gnd + rnd(0, 4999);
      if ($urandom_range(0, 9) == 0) fly_tick(5000, -5000, 5000, 0, 0);
      else fly_tick(100, -100, 100, 0, 0);
    end
    settle();

    // landed holds whatever comes; the other ends of the register ranges
    write_reg(REG_GROUND_ALT, 32'h0080_0000);
    write_reg(REG_LIFTOFF_ACC, 32'h0);
    write_reg(REG_LIFTOFF_HGT, 32'h0);
    write_reg(REG_BURNOUT_ACC, $urandom());
    write_reg(REG_BURNOUT_TIME, $urandom());
    write_reg(REG_COAST_HGT, 32'h0);
    write_reg(REG_LANDING_ACC, $urandom());
    write_reg(REG_LANDING_TIME, 32'h0);
    guard = (TICK_TARGET - ticks_sent > 100) ? TICK_TARGET - ticks_sent : 100;
    for (int i = 0; i < guard; i++) begin
      if (i % 64 == 0) burst = $urandom_range(0, 1);
      noise_tick();
    end
    burst = 0;

    settle();
    repeat (30) @(posedge clk);
    if (sb.pending() != 0) sb.report("words never returned", 0, sb.pending());
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[rocket_flight_phase_detector_top.f]
+incdir+rtl
rtl/rfpd_pkg.sv
rtl/rocket_flight_phase_detector_top.sv
test/tb_rocket_flight_phase_detector_top.sv
